@@ hw/rtl/sal_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants for the shift array list
// Field widths, operation and status codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package sal_pkg;

    // Field widths of one transfer
    localparam int FUNC_W       = 3;
    localparam int POS_W        = 6;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;

    // Default number of list entries
    localparam int CAPACITY_DEF = 64;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND  = 3'd0,
        FN_REMOVE  = 3'd1,
        FN_INSERT  = 3'd2,
        FN_ERASE   = 3'd3,
        FN_READ_AT = 3'd4,
        FN_FIRST   = 3'd5,
        FN_LAST    = 3'd6,
        FN_CLEAR   = 3'd7
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_R,
        S_INS_WR,
        S_SHIFT_L
    } state_t;

    // Read address select
    typedef enum logic [2:0] {
        RD_POS,
        RD_POS_INC,
        RD_FIRST,
        RD_LAST,
        RD_PTR_DEC,
        RD_PTR_INC
    } rd_sel_t;

    // Write address and data select
    typedef enum logic [1:0] {
        WR_APPEND,
        WR_SHIFT_R,
        WR_SHIFT_L,
        WR_INSERT
    } wr_sel_t;

    // Entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_cmd_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     accept;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        cnt_cmd_t cnt_cmd;
        logic     res_load;
        logic     res_use_rd;
        status_t  res_status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic zero;
        logic full;
        logic pos_gt_count;
        logic pos_ge_count;
        logic pos_eq_count;
        logic pos_eq_last;
        logic ptr_at_pos;
        logic ptr_at_last;
    } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/sal_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sal_ctrl: operation sequencer for the shift array list
// Decodes each accepted operation, steps the memory through entry shifts
// one entry per cycle and owns the result valid flag.
// ----------------------------------------------------------------------------
module sal_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire sal_pkg::func_t  func,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output sal_pkg::cmd_t        cmd,
    input  wire sal_pkg::stat_t  stat
);

    sal_pkg::state_t state_reg;
    sal_pkg::state_t state_next;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic            slot_free;
    logic            accept;

    // Take a new operation only when idle and the result slot is free
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == sal_pkg::S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;

    // State and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sal_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.accept     = accept;
        cmd.rd_sel     = sal_pkg::RD_POS;
        cmd.wr_sel     = sal_pkg::WR_APPEND;
        cmd.cnt_cmd    = sal_pkg::CNT_HOLD;
        cmd.res_status = sal_pkg::ST_OK;

        case (state_reg)
            sal_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        sal_pkg::FN_APPEND:
                        begin
                            cmd.res_load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = sal_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = sal_pkg::WR_APPEND;
                                cmd.cnt_cmd = sal_pkg::CNT_INC;
                            end
                        end
                        sal_pkg::FN_REMOVE:
                        begin
                            cmd.res_load = 1'b1;
                            if (stat.zero)
                                cmd.res_status = sal_pkg::ST_RANGE;
                            else
                                cmd.cnt_cmd = sal_pkg::CNT_DEC;
                        end
                        sal_pkg::FN_INSERT:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sal_pkg::ST_FULL;
                            end
                            else if (stat.pos_gt_count)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sal_pkg::ST_RANGE;
                            end
                            else if (stat.pos_eq_count)
                            begin
                                // insert at the end is an append
                                cmd.res_load = 1'b1;
                                cmd.wr_en    = 1'b1;
                                cmd.wr_sel   = sal_pkg::WR_APPEND;
                                cmd.cnt_cmd  = sal_pkg::CNT_INC;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sal_pkg::RD_LAST;
                                state_next = sal_pkg::S_SHIFT_R;
                            end
                        end
                        sal_pkg::FN_ERASE:
                        begin
                            if (stat.pos_ge_count)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sal_pkg::ST_RANGE;
                            end
                            else if (stat.pos_eq_last)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.cnt_cmd  = sal_pkg::CNT_DEC;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sal_pkg::RD_POS_INC;
                                state_next = sal_pkg::S_SHIFT_L;
                            end
                        end
                        sal_pkg::FN_READ_AT:
                        begin
                            if (stat.pos_ge_count)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sal_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sal_pkg::RD_POS;
                                state_next = sal_pkg::S_READ;
                            end
                        end
                        sal_pkg::FN_FIRST, sal_pkg::FN_LAST:
                        begin
                            if (stat.zero)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sal_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = (func == sal_pkg::FN_FIRST) ?
                                             sal_pkg::RD_FIRST : sal_pkg::RD_LAST;
                                state_next = sal_pkg::S_READ;
                            end
                        end
                        default:
                        begin
                            // clear
                            cmd.res_load = 1'b1;
                            cmd.cnt_cmd  = sal_pkg::CNT_CLR;
                        end
                    endcase
                end
            end

            sal_pkg::S_READ:
            begin
                // registered read data is ready
                cmd.res_load   = 1'b1;
                cmd.res_use_rd = 1'b1;
                state_next     = sal_pkg::S_IDLE;
            end

            sal_pkg::S_SHIFT_R:
            begin
                // move the entry read last cycle one place right
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sal_pkg::WR_SHIFT_R;
                if (stat.ptr_at_pos)
                begin
                    state_next = sal_pkg::S_INS_WR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sal_pkg::RD_PTR_DEC;
                end
            end

            sal_pkg::S_INS_WR:
            begin
                // drop the new value into the opened slot
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = sal_pkg::WR_INSERT;
                cmd.cnt_cmd  = sal_pkg::CNT_INC;
                cmd.res_load = 1'b1;
                state_next   = sal_pkg::S_IDLE;
            end

            sal_pkg::S_SHIFT_L:
            begin
                // move the entry read last cycle one place left
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sal_pkg::WR_SHIFT_L;
                if (stat.ptr_at_last)
                begin
                    cmd.cnt_cmd  = sal_pkg::CNT_DEC;
                    cmd.res_load = 1'b1;
                    state_next   = sal_pkg::S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sal_pkg::RD_PTR_INC;
                end
            end

            default:
            begin
                state_next = sal_pkg::S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, clear once the transfer completes
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.res_load)
            m_tvalid_next = 1'b1;
        else if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
    end

    // A result is loaded only into a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> slot_free)
        else $error("result loaded over a pending result");

    // Reaching the insert position always ends in the insert write
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sal_pkg::S_SHIFT_R) && stat.ptr_at_pos
        |=> state_reg == sal_pkg::S_INS_WR)
        else $error("right shift did not finish with insert write");

    // No new operation is taken while a sequence is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sal_pkg::S_IDLE) |-> !cmd.accept)
        else $error("operation accepted outside idle");

endmodule
`default_nettype wire

@@ hw/rtl/sal_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sal_dp: entry memory, count and result registers of the shift array list
// One write and one registered read per cycle; the controller picks the
// addresses. Compare flags go back to the controller.
// ----------------------------------------------------------------------------
module sal_dp #(
    parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sal_pkg::cmd_t                       cmd,
    output sal_pkg::stat_t                           stat,
    input  wire logic [sal_pkg::POS_W-1:0]           position,
    input  wire logic signed [sal_pkg::VALUE_W-1:0]  item_value,
    output logic signed [sal_pkg::VALUE_W-1:0]       read_value,
    output logic [sal_pkg::COUNT_W-1:0]              count,
    output logic                                     is_empty,
    output sal_pkg::status_t                         status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = sal_pkg::POS_W;
    localparam int VW = sal_pkg::VALUE_W;
    localparam int XW = ((CW > PW) ? CW : PW) + 1;

    logic [VW-1:0]        mem [CAPACITY];

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [PW-1:0]        op_pos_reg;
    logic [VW-1:0]        op_val_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic [VW-1:0]        rd_data_reg;
    logic [VW-1:0]        res_value_reg;
    logic [CW-1:0]        res_count_reg;
    logic                 res_empty_reg;
    sal_pkg::status_t     res_status_reg;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [VW-1:0]        wr_data;
    logic [AW-1:0]        last_addr;
    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;

    assign last_addr = AW'(count_reg - 1'b1);
    assign pos_x     = XW'(position);
    assign cnt_x     = XW'(count_reg);

    // Compare flags for the controller
    always_comb
    begin
        stat.zero         = (count_reg == '0);
        stat.full         = (count_reg == CW'(CAPACITY));
        stat.pos_gt_count = (pos_x > cnt_x);
        stat.pos_ge_count = (pos_x >= cnt_x);
        stat.pos_eq_count = (pos_x == cnt_x);
        stat.pos_eq_last  = ((pos_x + XW'(1)) == cnt_x);
        stat.ptr_at_pos   = (rd_addr_reg == AW'(op_pos_reg));
        stat.ptr_at_last  = (rd_addr_reg == last_addr);
    end

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            sal_pkg::RD_POS:     rd_addr = AW'(position);
            sal_pkg::RD_POS_INC: rd_addr = AW'(position) + AW'(1);
            sal_pkg::RD_FIRST:   rd_addr = '0;
            sal_pkg::RD_LAST:    rd_addr = last_addr;
            sal_pkg::RD_PTR_DEC: rd_addr = rd_addr_reg - AW'(1);
            sal_pkg::RD_PTR_INC: rd_addr = rd_addr_reg + AW'(1);
            default:             rd_addr = '0;
        endcase
    end

    // Write address and data select
    always_comb
    begin
        case (cmd.wr_sel)
            sal_pkg::WR_APPEND:
            begin
                wr_addr = AW'(count_reg);
                wr_data = item_value;
            end
            sal_pkg::WR_SHIFT_R:
            begin
                wr_addr = rd_addr_reg + AW'(1);
                wr_data = rd_data_reg;
            end
            sal_pkg::WR_SHIFT_L:
            begin
                wr_addr = rd_addr_reg - AW'(1);
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = AW'(op_pos_reg);
                wr_data = op_val_reg;
            end
        endcase
    end

    // Entry count update
    always_comb
    begin
        case (cmd.cnt_cmd)
            sal_pkg::CNT_INC: count_next = count_reg + 1'b1;
            sal_pkg::CNT_DEC: count_next = count_reg - 1'b1;
            sal_pkg::CNT_CLR: count_next = '0;
            default:          count_next = count_reg;
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Operand, read pointer and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_pos_reg <= position;
            op_val_reg <= item_value;
        end
        if (cmd.rd_en)
            rd_addr_reg <= rd_addr;
        if (cmd.res_load)
        begin
            res_value_reg  <= cmd.res_use_rd ? rd_data_reg : '0;
            res_count_reg  <= count_next;
            res_empty_reg  <= (count_next == '0);
            res_status_reg <= cmd.res_status;
        end
    end

    assign read_value = res_value_reg;
    assign count      = sal_pkg::COUNT_W'(res_count_reg);
    assign is_empty   = res_empty_reg;
    assign status     = res_status_reg;

    // Count stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // Shift steps never read and write the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en && cmd.rd_en |-> wr_addr != rd_addr)
        else $error("read and write collide on one entry");

endmodule
`default_nettype wire

@@ hw/rtl/shift_array_list.sv @@
`default_nettype none
// Append, remove last, clear and any rejected operation load their result
//   in the accepting cycle; reads load theirs in S_READ from the registered read data.
// Insert before the end steps through S_SHIFT_R and S_INS_WR, erase before the
//   last entry through S_SHIFT_L: the memory moves one entry a cycle over its one read and one write port.
// One operation is in flight at a time; the next is taken once the result slot frees.
// Reset clears the count and the result valid; stored words need no clearing.
// ----------------------------------------------------------------------------
// shift_array_list: bounded ordered list of signed 32-bit words
// Append, remove last, insert, erase, indexed/first/last read and clear,
// each answered by one result with value, count, empty flag and status.
// ----------------------------------------------------------------------------
module shift_array_list #(
    parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Operation stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [5:0] position, [37:6] item_value, zero pad
    input  wire logic [2:0]  s_tuser,   // [2:0] func
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [31:0] read_value, [38:32] count,
                                        // [39] is_empty, [41:40] status, zero pad
);

    sal_pkg::cmd_t                        cmd;
    sal_pkg::stat_t                       stat;
    sal_pkg::func_t                       func;
    logic signed [sal_pkg::VALUE_W-1:0]   read_value;
    logic [sal_pkg::COUNT_W-1:0]          count;
    logic                                 is_empty;
    sal_pkg::status_t                     status;

    assign func = sal_pkg::func_t'(s_tuser);

    sal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (func),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .position   (s_tdata[5:0]),
        .item_value (s_tdata[37:6]),
        .read_value (read_value),
        .count      (count),
        .is_empty   (is_empty),
        .status     (status)
    );

    // Pack result fields from the lowest bit up
    assign m_tdata = {6'b0, status, is_empty, count, read_value};

endmodule
`default_nettype wire

@@ dv/tb_shift_array_list.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_shift_array_list: self-checking bench for the shift array list
// Drives list operations on the operation stream and keeps its own model of
// the list contents and count. Every result transfer is compared field by
// field against the oldest predicted result. A short directed table covers
// the empty, out-of-range and value-extreme cases. Random phases that grow, shrink
// or churn the list follow it. Both stream sides stall at random outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_shift_array_list;

    localparam int LIST_DEPTH   = sal_pkg::CAPACITY_DEF;
    localparam int RANDOM_OPS   = 1525;
    localparam int SETTLE_TICKS = 80;

    // One predicted result
    typedef struct packed {
        logic [sal_pkg::VALUE_W-1:0]  rd;
        logic [sal_pkg::COUNT_W-1:0]  cnt;
        logic                         empty;
        sal_pkg::status_t             st;
    } list_result_t;

    // One directed stimulus row; typed rows carry their own expected result
    typedef struct packed {
        sal_pkg::func_t               fn;
        logic [sal_pkg::POS_W-1:0]    pos;
        logic [sal_pkg::VALUE_W-1:0]  val;
        logic                         typed;
        list_result_t                 want;
    } directed_row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata = '0;   // [5:0] position, [37:6] item_value, zero pad
    logic [2:0]         s_tuser = '0;   // [2:0] func
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;        // [31:0] read_value, [38:32] count,
                                        // [39] is_empty, [41:40] status, zero pad

    // Model of the list held by the bench
    logic [sal_pkg::VALUE_W-1:0] list_words [LIST_DEPTH];
    int unsigned        list_len = 0;

    list_result_t       pending_results [$];
    int unsigned        mismatch_count = 0;
    logic               steady = 1'b0;  // no idling on either side while set
    directed_row_t      directed_rows [25];

    shift_array_list #(
        .CAPACITY (LIST_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        #(12 * 500000);
        $display("tb_shift_array_list failed");
        $finish;
    end

    // Apply one operation to the list model and return its result
    function automatic list_result_t apply_op(sal_pkg::func_t fn,
                                              logic [sal_pkg::POS_W-1:0] pos,
                                              logic [sal_pkg::VALUE_W-1:0] val);
        list_result_t res;
        int unsigned  idx;
        res = '0;
        res.st = sal_pkg::ST_OK;
        case (fn)
            sal_pkg::FN_APPEND:
                if (list_len >= LIST_DEPTH)
                    res.st = sal_pkg::ST_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
            sal_pkg::FN_REMOVE:
                if (list_len == 0)
                    res.st = sal_pkg::ST_RANGE;
                else
                    list_len--;
            sal_pkg::FN_INSERT:
                // full wins over a bad position
                if (list_len >= LIST_DEPTH)
                    res.st = sal_pkg::ST_FULL;
                else if (pos > list_len)
                    res.st = sal_pkg::ST_RANGE;
                else
                begin
                    for (idx = list_len; idx > pos; idx--)
                        list_words[idx] = list_words[idx-1];
                    list_words[pos] = val;
                    list_len++;
                end
            sal_pkg::FN_ERASE:
                if (pos >= list_len)
                    res.st = sal_pkg::ST_RANGE;
                else
                begin
                    for (idx = pos; idx + 1 < list_len; idx++)
                        list_words[idx] = list_words[idx+1];
                    list_len--;
                end
            sal_pkg::FN_READ_AT:
                if (pos >= list_len)
                    res.st = sal_pkg::ST_RANGE;
                else
                    res.rd = list_words[pos];
            sal_pkg::FN_FIRST:
                if (list_len == 0)
                    res.st = sal_pkg::ST_RANGE;
                else
                    res.rd = list_words[0];
            sal_pkg::FN_LAST:
                if (list_len == 0)
                    res.st = sal_pkg::ST_RANGE;
                else
                    res.rd = list_words[list_len-1];
            default:
                list_len = 0;
        endcase
        res.cnt   = 7'(list_len);
        res.empty = (list_len == 0);
        return res;
    endfunction

    // Drive one operation, wait for its transfer, then queue its result
    task automatic send_op(sal_pkg::func_t fn, logic [sal_pkg::POS_W-1:0] pos,
                           logic [sal_pkg::VALUE_W-1:0] val,
                           logic typed, list_result_t want);
        list_result_t predicted;
        while (!steady && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {2'b00, val, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_op(fn, pos, val);
        if (typed)
            predicted = want;
        pending_results = {pending_results, predicted};
        @(negedge clk);
    endtask

    // Result side: random backpressure
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 7);

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.rd)
                begin
                    mismatch_count++;
                    $display("%0t: read_value expected %h got %h",
                             $time, want.rd, m_tdata[31:0]);
                end
                if (m_tdata[38:32] !== want.cnt)
                begin
                    mismatch_count++;
                    $display("%0t: count expected %0d got %0d",
                             $time, want.cnt, m_tdata[38:32]);
                end
                if (m_tdata[39] !== want.empty)
                begin
                    mismatch_count++;
                    $display("%0t: is_empty expected %b got %b",
                             $time, want.empty, m_tdata[39]);
                end
                if (m_tdata[41:40] !== want.st)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.st, m_tdata[41:40]);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int                          mode;
        int                          phase_left;
        int unsigned                 roll;
        sal_pkg::func_t              fn;
        logic [sal_pkg::POS_W-1:0]   pos;
        logic [sal_pkg::VALUE_W-1:0] val;

        directed_rows = '{
            // empty list: every removal and read is rejected
            '{sal_pkg::FN_REMOVE, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_FIRST, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_LAST, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_READ_AT, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_ERASE, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_INSERT, 6'd1, 32'd5, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            // value extremes
            '{sal_pkg::FN_INSERT, 6'd0, 32'h7FFFFFFF, 1'b1,
              '{32'd0, 7'd1, 1'b0, sal_pkg::ST_OK}},
            '{sal_pkg::FN_APPEND, 6'd0, 32'h80000000, 1'b1,
              '{32'd0, 7'd2, 1'b0, sal_pkg::ST_OK}},
            '{sal_pkg::FN_FIRST, 6'd0, 32'd0, 1'b1,
              '{32'h7FFFFFFF, 7'd2, 1'b0, sal_pkg::ST_OK}},
            '{sal_pkg::FN_LAST, 6'd0, 32'd0, 1'b1,
              '{32'h80000000, 7'd2, 1'b0, sal_pkg::ST_OK}},
            '{sal_pkg::FN_READ_AT, 6'd63, 32'd0, 1'b1,
              '{32'd0, 7'd2, 1'b0, sal_pkg::ST_RANGE}},
            // insert at the end and in the middle
            '{sal_pkg::FN_INSERT, 6'd2, 32'd0, 1'b0, '0},
            '{sal_pkg::FN_INSERT, 6'd1, 32'hFFFFFFFF, 1'b0, '0},
            '{sal_pkg::FN_INSERT, 6'd5, 32'd9, 1'b1, '{32'd0, 7'd4, 1'b0, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_READ_AT, 6'd1, 32'd0, 1'b0, '0},
            // erase the last entry, then the first
            '{sal_pkg::FN_ERASE, 6'd3, 32'd0, 1'b0, '0},
            '{sal_pkg::FN_ERASE, 6'd0, 32'd0, 1'b0, '0},
            '{sal_pkg::FN_READ_AT, 6'd0, 32'd0, 1'b0, '0},
            '{sal_pkg::FN_ERASE, 6'd2, 32'd0, 1'b1, '{32'd0, 7'd2, 1'b0, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_REMOVE, 6'd0, 32'd0, 1'b0, '0},
            '{sal_pkg::FN_APPEND, 6'd0, 32'h12345678, 1'b0, '0},
            // clear keeps words but hides them
            '{sal_pkg::FN_CLEAR, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_OK}},
            '{sal_pkg::FN_READ_AT, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_RANGE}},
            '{sal_pkg::FN_CLEAR, 6'd0, 32'd0, 1'b1, '{32'd0, 7'd0, 1'b1, sal_pkg::ST_OK}},
            '{sal_pkg::FN_APPEND, 6'd0, 32'h55555555, 1'b0, '0}
        };

        // Hold reset, then release it on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
            send_op(directed_rows[i].fn, directed_rows[i].pos, directed_rows[i].val,
                    directed_rows[i].typed, directed_rows[i].want);

        // Random phases: grow first so the full case is reached early
        mode = 0;
        phase_left = $urandom_range(160, 100);
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            steady <= (n >= 700 && n < 1000);
            if (phase_left == 0)
            begin
                mode = $urandom_range(2);
                phase_left = $urandom_range(160, 80);
            end
            phase_left--;

            // pick the operation by phase: 0 grow, 1 churn, 2 shrink
            roll = $urandom_range(99);
            if (roll < 1)
                fn = sal_pkg::FN_CLEAR;
            else if (mode == 0)
                fn = (roll < 85) ?
                     ((roll & 1) ? sal_pkg::FN_INSERT : sal_pkg::FN_APPEND)
                     : sal_pkg::func_t'($urandom_range(6));
            else if (mode == 2)
                fn = (roll < 60) ?
                     ((roll & 1) ? sal_pkg::FN_ERASE : sal_pkg::FN_REMOVE)
                     : sal_pkg::func_t'($urandom_range(6));
            else
                fn = sal_pkg::func_t'($urandom_range(6));

            // mostly legal positions, some anywhere in the field
            if ($urandom_range(99) < 10)
                pos = sal_pkg::POS_W'($urandom_range(63));
            else if (fn == sal_pkg::FN_INSERT)
                pos = sal_pkg::POS_W'($urandom_range((list_len > 63) ? 63 : list_len));
            else
                pos = sal_pkg::POS_W'($urandom_range((list_len == 0) ? 0 : list_len - 1));

            roll = $urandom_range(19);
            if (roll == 0)
                val = 32'h80000000;
            else if (roll == 1)
                val = 32'h7FFFFFFF;
            else if (roll == 2)
                val = 32'hFFFFFFFF;
            else
                val = $urandom;

            send_op(fn, pos, val, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_shift_array_list passed");
        else
            $display("tb_shift_array_list failed");
        $finish;
    end

endmodule
`default_nettype wire
